// ----- sv/ifc_pkg.sv -----
// ----------------------------------------------------------------------------
// ifc_pkg: shared types and constants of the 3x3 image filter
// Pixel, coefficient and accumulator types, register map, cell control word.
// ----------------------------------------------------------------------------
package ifc_pkg;

    localparam int PIX_W          = 16;
    localparam int COEF_W         = 32;
    localparam int ACC_W          = 32;
    localparam int KERN_N         = 3;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 13;
    localparam int APB_AW         = 6;
    localparam int APB_DW         = 64;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    typedef logic signed [PIX_W-1:0]  t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // register index = paddr[5:3]
    typedef enum logic [2:0] {
        REG_COEF_PAIR_0  = 3'd0,
        REG_COEF_PAIR_1  = 3'd1,
        REG_COEF_PAIR_2  = 3'd2,
        REG_COEF_PAIR_3  = 3'd3,
        REG_COEF_LAST    = 3'd4,
        REG_IMAGE_WIDTH  = 3'd5,
        REG_IMAGE_HEIGHT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic shift;    // new pixel column enters the window
        logic en_prod;  // product stage advances
        logic en_sum;   // column sum stage advances
    } t_cell_ctrl;

endpackage

// ----- sv/ifc_pix_if.sv -----
// ----------------------------------------------------------------------------
// ifc_pix_if: pixel input channel
// Valid/ready channel carrying one signed pixel per word.
// ----------------------------------------------------------------------------
interface ifc_pix_if;
    logic          valid;
    logic          ready;
    ifc_pkg::t_pix pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- sv/ifc_res_if.sv -----
// ----------------------------------------------------------------------------
// ifc_res_if: filter result channel
// Valid/ready channel carrying one filtered value and an end-of-frame flag.
// ----------------------------------------------------------------------------
interface ifc_res_if;
    logic          valid;
    logic          ready;
    ifc_pkg::t_acc filtered_value;
    logic          last_of_frame;

    modport source (output valid, output filtered_value, output last_of_frame, input ready);
    modport sink   (input valid, input filtered_value, input last_of_frame, output ready);
endinterface

// ----- sv/image_filter_3x3_core.sv -----
// ----------------------------------------------------------------------------
// image_filter_3x3_core: streaming 3x3 convolution with line buffers
//
// i_pix takes one word per cycle: pixels of a frame padded by one pixel on
// each side, (width+2) per row, (height+2) rows, raster order. o_res gives
// one word per inner pixel: the wrapped 32-bit sum of nine products with
// the kernel, last_of_frame set on the frame's final word. Pixels of the
// first two rows or columns fill the line buffers and window but give no word.
// Throughput: one pixel per cycle, set by the line buffers (one read and one
// write each per pixel) and the three window cells that all advance on the
// same accepted pixel.
// A result word passes four registered stages after its pixel is accepted:
// window, products, column sums, output register.
// The APB port holds the kernel (four coefficient pairs and the last
// coefficient) and the frame size; writing width or height restarts the
// frame. Write it only while the pipeline is empty.
// Reset clears counters, pipeline valids and registers (size 1x1, kernel 0);
// line buffer contents are left as they are.
// When o_res stalls, the four stages fill and then i_pix.ready drops;
// bubbles are squeezed out first.
// ----------------------------------------------------------------------------
module image_filter_3x3_core #(
    parameter int MAX_WIDTH  = ifc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ifc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ifc_pix_if.sink                      i_pix,
    ifc_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ifc_pkg::APB_AW-1:0]   paddr,
    input  logic [ifc_pkg::APB_DW-1:0]   pwdata,
    output logic [ifc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    localparam int LINE_DEPTH = MAX_WIDTH + 2;
    localparam int CW         = $clog2(LINE_DEPTH);
    localparam int RW         = $clog2(MAX_HEIGHT + 2);
    localparam int KN         = ifc_pkg::KERN_N;

    // configuration
    ifc_pkg::t_coef                       r_coef [KN*KN];
    logic [ifc_pkg::WIDTH_REG_W-1:0]      r_image_width;
    logic [ifc_pkg::HEIGHT_REG_W-1:0]     r_image_height;
    logic                                 cfg_we;
    ifc_pkg::t_reg_idx                    cfg_idx;
    logic                                 size_wr;

    // frame position
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [31:0]   w_req, h_req;
    logic [CW-1:0] w_eff, w_last;
    logic [RW-1:0] h_eff, h_last;
    logic          is_res, is_last;

    // pipeline control
    logic e1, e2, e3, e4, in_fire;
    logic r_v1, r_v2, r_v3, r_v4;
    logic r_last1, r_last2, r_last3, r_last4;
    ifc_pkg::t_acc r_out;

    // data path
    ifc_pkg::t_pix  top_pix, mid_pix;
    ifc_pkg::t_pix  new_col [KN];
    ifc_pkg::t_pix  col_pix [KN][KN];
    ifc_pkg::t_coef kcol    [KN][KN];
    ifc_pkg::t_acc  col_sum [KN];
    ifc_pkg::t_cell_ctrl cell_ctrl;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = ifc_pkg::t_reg_idx'(paddr[5:3]);
    assign size_wr = cfg_we && (cfg_idx == ifc_pkg::REG_IMAGE_WIDTH ||
                                cfg_idx == ifc_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KN*KN; i++) begin
                r_coef[i] <= '0;
            end
            r_image_width  <= ifc_pkg::WIDTH_REG_W'(1);
            r_image_height <= ifc_pkg::HEIGHT_REG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                ifc_pkg::REG_COEF_PAIR_0: begin
                    r_coef[0] <= pwdata[31:0];
                    r_coef[1] <= pwdata[63:32];
                end
                ifc_pkg::REG_COEF_PAIR_1: begin
                    r_coef[2] <= pwdata[31:0];
                    r_coef[3] <= pwdata[63:32];
                end
                ifc_pkg::REG_COEF_PAIR_2: begin
                    r_coef[4] <= pwdata[31:0];
                    r_coef[5] <= pwdata[63:32];
                end
                ifc_pkg::REG_COEF_PAIR_3: begin
                    r_coef[6] <= pwdata[31:0];
                    r_coef[7] <= pwdata[63:32];
                end
                ifc_pkg::REG_COEF_LAST: begin
                    r_coef[8] <= pwdata[31:0];
                end
                ifc_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= pwdata[ifc_pkg::WIDTH_REG_W-1:0];
                end
                ifc_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= pwdata[ifc_pkg::HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            ifc_pkg::REG_COEF_PAIR_0:  prdata = {r_coef[1], r_coef[0]};
            ifc_pkg::REG_COEF_PAIR_1:  prdata = {r_coef[3], r_coef[2]};
            ifc_pkg::REG_COEF_PAIR_2:  prdata = {r_coef[5], r_coef[4]};
            ifc_pkg::REG_COEF_PAIR_3:  prdata = {r_coef[7], r_coef[6]};
            ifc_pkg::REG_COEF_LAST:    prdata = {32'd0, r_coef[8]};
            ifc_pkg::REG_IMAGE_WIDTH:  prdata = ifc_pkg::APB_DW'(r_image_width);
            ifc_pkg::REG_IMAGE_HEIGHT: prdata = ifc_pkg::APB_DW'(r_image_height);
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------ frame counters
    assign w_req = 32'(r_image_width);
    assign h_req = 32'(r_image_height);

    // zero reads as one, oversize as the maximum
    always_comb begin
        if (w_req == 32'd0) begin
            w_eff = CW'(1);
        end else if (w_req > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(w_req);
        end
        if (h_req == 32'd0) begin
            h_eff = RW'(1);
        end else if (h_req > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(h_req);
        end
    end

    assign w_last  = w_eff + CW'(1);
    assign h_last  = h_eff + RW'(1);
    assign is_res  = (r_row >= RW'(2)) && (r_col >= CW'(2));
    assign is_last = (r_row == h_last) && (r_col == w_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (size_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (in_fire) begin
            if (r_col == w_last) begin
                n_col = '0;
                n_row = (r_row == h_last) ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------ pipeline
    assign e4      = !r_v4 || o_res.ready;
    assign e3      = !r_v3 || e4;
    assign e2      = !r_v2 || e3;
    assign e1      = !r_v1 || e2;
    assign in_fire = i_pix.valid && e1;
    assign i_pix.ready = e1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (e1) r_v1 <= in_fire && is_res;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) r_last1 <= is_last;
        if (e2) r_last2 <= r_last1;
        if (e3) r_last3 <= r_last2;
        if (e4) begin
            r_last4 <= r_last3;
            r_out   <= col_sum[0] + col_sum[1] + col_sum[2];
        end
    end

    assign o_res.valid          = r_v4;
    assign o_res.filtered_value = r_out;
    assign o_res.last_of_frame  = r_last4;

    // -------------------------------------------------------- line buffers
    // read address runs one word ahead so data is ready at the next accept
    ifc_line_ram #(.DEPTH(LINE_DEPTH)) u_line_older (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_col),
        .i_wdata (mid_pix),
        .i_raddr (n_col),
        .o_rdata (top_pix)
    );

    ifc_line_ram #(.DEPTH(LINE_DEPTH)) u_line_newer (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_col),
        .i_wdata (i_pix.pixel),
        .i_raddr (n_col),
        .o_rdata (mid_pix)
    );

    // ------------------------------------------------------- window cells
    assign cell_ctrl = '{shift: in_fire, en_prod: e2, en_sum: e3};

    always_comb begin
        new_col[0] = top_pix;
        new_col[1] = mid_pix;
        new_col[2] = i_pix.pixel;
        for (int c = 0; c < KN; c++) begin
            for (int r = 0; r < KN; r++) begin
                kcol[c][r] = r_coef[r*KN + c];
            end
        end
    end

    // cell 2 holds the newest column, cell 0 the oldest
    ifc_cell u_cell2 (
        .i_clk  (i_clk),
        .i_ctrl (cell_ctrl),
        .i_pix  (new_col),
        .i_coef (kcol[2]),
        .o_pix  (col_pix[2]),
        .o_sum  (col_sum[2])
    );

    ifc_cell u_cell1 (
        .i_clk  (i_clk),
        .i_ctrl (cell_ctrl),
        .i_pix  (col_pix[2]),
        .i_coef (kcol[1]),
        .o_pix  (col_pix[1]),
        .o_sum  (col_sum[1])
    );

    ifc_cell u_cell0 (
        .i_clk  (i_clk),
        .i_ctrl (cell_ctrl),
        .i_pix  (col_pix[1]),
        .i_coef (kcol[0]),
        .o_pix  (col_pix[0]),
        .o_sum  (col_sum[0])
    );

    // ---------------------------------------------------------- assertions
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= w_last)
        else $error("column counter beyond padded row");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !o_res.ready))
        else $error("input stalled with a free pipeline stage");

    a_out_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_v3))
        else $error("result word without a column sum behind it");

    a_last_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !size_wr && is_last) |=> (r_v1 && r_last1 && r_col == '0 && r_row == '0))
        else $error("frame end not tracked into the window stage");

endmodule

// ----- sv/ifc_line_ram.sv -----
// ----------------------------------------------------------------------------
// ifc_line_ram: one line buffer
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module ifc_line_ram #(
    parameter int DEPTH = ifc_pkg::MAX_WIDTH_DEF + 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ifc_pkg::t_pix            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ifc_pkg::t_pix            o_rdata
);

    ifc_pkg::t_pix r_mem [DEPTH];
    ifc_pkg::t_pix r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ifc_cell.sv -----
// ----------------------------------------------------------------------------
// ifc_cell: one window column
// Holds three pixels of a column, hands them to the older neighbor on each
// shift, multiplies them by its kernel column and sums the three products.
// ----------------------------------------------------------------------------
module ifc_cell (
    input  logic               i_clk,
    input  ifc_pkg::t_cell_ctrl i_ctrl,
    input  ifc_pkg::t_pix      i_pix  [ifc_pkg::KERN_N],
    input  ifc_pkg::t_coef     i_coef [ifc_pkg::KERN_N],
    output ifc_pkg::t_pix      o_pix  [ifc_pkg::KERN_N],
    output ifc_pkg::t_acc      o_sum
);

    localparam int FULL_W = ifc_pkg::COEF_W + ifc_pkg::PIX_W;

    ifc_pkg::t_pix          r_pix  [ifc_pkg::KERN_N];
    ifc_pkg::t_acc          r_prod [ifc_pkg::KERN_N];
    ifc_pkg::t_acc          r_sum;
    logic signed [FULL_W-1:0] n_full [ifc_pkg::KERN_N];

    always_comb begin
        for (int i = 0; i < ifc_pkg::KERN_N; i++) begin
            n_full[i] = i_coef[i] * r_pix[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            for (int i = 0; i < ifc_pkg::KERN_N; i++) begin
                r_pix[i] <= i_pix[i];
            end
        end
        if (i_ctrl.en_prod) begin
            // only the low word of the product matters: sum wraps mod 2^32
            for (int i = 0; i < ifc_pkg::KERN_N; i++) begin
                r_prod[i] <= n_full[i][ifc_pkg::ACC_W-1:0];
            end
        end
        if (i_ctrl.en_sum) begin
            r_sum <= r_prod[0] + r_prod[1] + r_prod[2];
        end
    end

    assign o_pix = r_pix;
    assign o_sum = r_sum;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for image_filter_3x3_core
// Streams padded frames through the pixel channel, predicts every filtered
// word from a local model of the line buffers, window and kernel, and
// compares each result word in order. Covers register writes and readback,
// size clamping, frames cut short by a size write, and mid-frame kernel
// changes, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int          MAX_W      = ifc_pkg::MAX_WIDTH_DEF;
    localparam int          MAX_H      = ifc_pkg::MAX_HEIGHT_DEF;
    localparam int          LINE_DEPTH = MAX_W + 2;
    localparam int          LAT_WAIT   = 8;
    localparam int          RAND_PIX   = 1200;
    localparam int          CLAMP_PIX  = 30;
    localparam int unsigned CYCLE_CAP  = 600000;

    typedef struct packed {
        ifc_pkg::t_acc value;
        logic          last;
    } t_result;

    typedef enum logic {ROW_PIX, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        ifc_pkg::t_reg_idx sel;
        logic [63:0]       data;
        ifc_pkg::t_pix     pixel;
        logic              typed;
        ifc_pkg::t_acc     exp_value;
        logic              exp_last;
    } t_dir_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ifc_pkg::APB_AW-1:0]  paddr;
    logic [ifc_pkg::APB_DW-1:0]  pwdata;
    logic [ifc_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    ifc_pix_if pix_if ();
    ifc_res_if res_if ();

    image_filter_3x3_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    // local copy of the filter state
    logic [15:0]  line_old [LINE_DEPTH];
    logic [15:0]  line_new [LINE_DEPTH];
    logic [15:0]  win [9];
    logic [31:0]  coef [9];
    logic [10:0]  width_raw;
    logic [12:0]  height_raw;
    int unsigned  col_pos;
    int unsigned  row_pos;

    t_result      expected_sums [$];

    int unsigned  cycles;
    int unsigned  n_errors;
    int unsigned  n_checked;
    int unsigned  n_frames;
    int unsigned  n_pixels;
    int unsigned  n_writes;
    int unsigned  n_cut;
    int unsigned  rnd_sent;
    bit           no_gaps;

    // kind, register, data, pixel, typed, expected value, expected last
    t_dir_row directed_rows [37] = '{
        // size 1x1 and zero kernel out of reset: one zero word per frame
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0001, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h5555, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'hAAAA, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h1234, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h8001, 1'b1, 32'h0, 1'b1},
        // center tap only: the word is the center pixel
        '{ROW_CFG, ifc_pkg::REG_COEF_PAIR_2, 64'h0000_0000_0000_0001, 16'h0, 1'b0,
          32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0001, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0002, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0003, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0004, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0006, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0007, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0008, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0009, 1'b1, 32'h0000_7FFF, 1'b1},
        // extreme kernel, zero sizes that act as 1
        '{ROW_CFG, ifc_pkg::REG_COEF_PAIR_0, 64'h7FFF_FFFF_8000_0000, 16'h0, 1'b0,
          32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_COEF_PAIR_1, 64'hFFFF_FFFF_0000_0001, 16'h0, 1'b0,
          32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_COEF_PAIR_2, 64'h8000_0000_FFFF_FFFF, 16'h0, 1'b0,
          32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_COEF_PAIR_3, 64'h0000_0001_7FFF_FFFF, 16'h0, 1'b0,
          32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_COEF_LAST,   64'h0000_0000_8000_0000, 16'h0, 1'b0,
          32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_IMAGE_WIDTH, 64'h0, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_IMAGE_HEIGHT, 64'h0, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h7FFF, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h8000, 1'b0, 32'h0, 1'b0},
        '{ROW_PIX, ifc_pkg::REG_COEF_PAIR_0, 64'h0, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_IMAGE_WIDTH, 64'h1, 16'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG, ifc_pkg::REG_IMAGE_HEIGHT, 64'h1, 16'h0, 1'b0, 32'h0, 1'b0}
    };

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void apply_setting(input ifc_pkg::t_reg_idx sel,
                                          input logic [63:0] data);
        case (sel)
            ifc_pkg::REG_COEF_PAIR_0, ifc_pkg::REG_COEF_PAIR_1,
            ifc_pkg::REG_COEF_PAIR_2, ifc_pkg::REG_COEF_PAIR_3: begin
                coef[2*int'(sel)]   = data[31:0];
                coef[2*int'(sel)+1] = data[63:32];
            end
            ifc_pkg::REG_COEF_LAST: begin
                coef[8] = data[31:0];
            end
            ifc_pkg::REG_IMAGE_WIDTH: begin
                width_raw = data[10:0];
                col_pos   = 0;
                row_pos   = 0;
            end
            ifc_pkg::REG_IMAGE_HEIGHT: begin
                height_raw = data[12:0];
                col_pos    = 0;
                row_pos    = 0;
            end
            default: ;
        endcase
    endfunction

    // shift one pixel through line buffers and window; returns 1 on a result
    function automatic bit conv_step(input ifc_pkg::t_pix px, output t_result res);
        int unsigned w, h, c;
        int          r, k;
        logic [15:0] top, mid;
        logic [31:0] acc;
        bit          hit;
        w = eff_size(width_raw, MAX_W);
        h = eff_size(height_raw, MAX_H);
        c = col_pos;
        if (c >= LINE_DEPTH)
            c = 0;
        top = line_old[c];
        mid = line_new[c];
        line_old[c] = mid;
        line_new[c] = px;
        for (r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        hit = (row_pos >= 2) && (c >= 2);
        res = '0;
        if (hit) begin
            acc = '0;
            for (k = 0; k < 9; k++)
                acc += coef[k] * {{16{win[k][15]}}, win[k]};
            res.value = acc;
            res.last  = (row_pos == h + 1) && (c == w + 1);
        end
        c++;
        if (c >= w + 2) begin
            c = 0;
            row_pos++;
            if (row_pos >= h + 2)
                row_pos = 0;
        end
        col_pos = c;
        return hit;
    endfunction

    function automatic ifc_pkg::t_pix rand_pixel();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return ifc_pkg::t_pix'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_coef();
        ifc_pkg::t_coef lo, hi;
        lo = $urandom_range(0, 6) - 3;
        hi = $urandom_range(0, 6) - 3;
        case ($urandom_range(0, 9))
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_8000_0000;
            3: return 64'h7FFF_FFFF_7FFF_FFFF;
            4, 5: return {hi, lo};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input ifc_pkg::t_pix px, input bit typed,
                              input t_result typed_res);
        t_result r;
        bit      got;
        while (!no_gaps && $urandom_range(0, 99) < 13) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= px;
        @(posedge i_clk);
        while (!pix_if.ready)
            @(posedge i_clk);
        got = conv_step(px, r);
        if (typed) begin
            r   = typed_res;
            got = 1'b1;
        end
        if (got)
            expected_sums.push_back(r);
        n_pixels++;
        @(negedge i_clk);
    endtask

    // stop sending and let the pipeline empty
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (expected_sums.size() != 0)
            @(negedge i_clk);
        repeat (LAT_WAIT) @(negedge i_clk);
    endtask

    task automatic reg_write(input ifc_pkg::t_reg_idx sel, input logic [63:0] data);
        logic [63:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        apply_setting(sel, data);
        n_writes++;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (sel)
            ifc_pkg::REG_COEF_LAST:    mask = 64'hFFFF_FFFF;
            ifc_pkg::REG_IMAGE_WIDTH:  mask = 64'h7FF;
            ifc_pkg::REG_IMAGE_HEIGHT: mask = 64'h1FFF;
            default:                   mask = '1;
        endcase
        if (((prdata ^ data) & mask) != 0) begin
            $display("%0t readback mismatch reg %s: expected %h actual %h",
                     $time, sel.name(), data & mask, prdata & mask);
            n_errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic new_setting();
        int k;
        settle();
        for (k = 0; k <= int'(ifc_pkg::REG_COEF_LAST); k++)
            if ($urandom_range(0, 2) == 0)
                reg_write(ifc_pkg::t_reg_idx'(k), rand_coef());
        if ($urandom_range(0, 3) != 0)
            case ($urandom_range(0, 19))
                0: reg_write(ifc_pkg::REG_IMAGE_WIDTH, 64'd0);
                1: reg_write(ifc_pkg::REG_IMAGE_WIDTH, 64'($urandom_range(7, 24)));
                default: reg_write(ifc_pkg::REG_IMAGE_WIDTH, 64'($urandom_range(1, 6)));
            endcase
        if ($urandom_range(0, 3) != 0)
            case ($urandom_range(0, 19))
                0: reg_write(ifc_pkg::REG_IMAGE_HEIGHT, 64'd0);
                1: reg_write(ifc_pkg::REG_IMAGE_HEIGHT, 64'($urandom_range(5, 10)));
                default: reg_write(ifc_pkg::REG_IMAGE_HEIGHT, 64'($urandom_range(1, 4)));
            endcase
    endtask

    // one frame of the current size; shaken frames may be cut short by a
    // size write or paused for a kernel change
    task automatic run_frame(input bit shaken);
        int unsigned npix, cut_at, pause_at, k;
        bit          cut;
        npix     = (eff_size(width_raw, MAX_W) + 2) * (eff_size(height_raw, MAX_H) + 2);
        cut      = shaken && ($urandom_range(0, 7) == 0);
        cut_at   = cut ? $urandom_range(1, npix - 1) : npix;
        pause_at = (shaken && $urandom_range(0, 4) == 0) ? $urandom_range(1, npix - 1) : npix;
        for (k = 0; k < cut_at; k++) begin
            if (k == pause_at) begin
                settle();
                if ($urandom_range(0, 1) != 0)
                    reg_write(ifc_pkg::t_reg_idx'($urandom_range(0,
                              int'(ifc_pkg::REG_COEF_LAST))), rand_coef());
            end
            no_gaps = shaken && (rnd_sent >= 400) && (rnd_sent < 600);
            send_pixel(rand_pixel(), 1'b0, '0);
            if (shaken)
                rnd_sent++;
        end
        if (cut) begin
            settle();
            n_cut++;
            if ($urandom_range(0, 1) != 0)
                reg_write(ifc_pkg::REG_IMAGE_WIDTH, 64'(width_raw));
            else
                reg_write(ifc_pkg::REG_IMAGE_HEIGHT, 64'(height_raw));
        end
    endtask

    // a short stretch of a frame at an oversize setting, then back to a
    // small frame
    task automatic run_clamped(input logic [63:0] w_val, input logic [63:0] h_val);
        int k;
        settle();
        reg_write(ifc_pkg::REG_IMAGE_WIDTH, w_val);
        reg_write(ifc_pkg::REG_IMAGE_HEIGHT, h_val);
        for (k = 0; k < CLAMP_PIX; k++)
            send_pixel(rand_pixel(), 1'b0, '0);
        settle();
        n_cut++;
        reg_write(ifc_pkg::REG_IMAGE_WIDTH, 64'd3);
        reg_write(ifc_pkg::REG_IMAGE_HEIGHT, 64'd2);
    endtask

    always @(negedge i_clk)
        res_if.ready <= no_gaps || ($urandom_range(0, 99) >= 13);

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h last %b",
                         $time, res_if.filtered_value, res_if.last_of_frame);
                n_errors++;
            end else begin
                want = expected_sums.pop_front();
                n_checked++;
                if (res_if.filtered_value !== want.value) begin
                    $display("%0t value mismatch: expected %h actual %h",
                             $time, want.value, res_if.filtered_value);
                    n_errors++;
                end
                if (res_if.last_of_frame !== want.last) begin
                    $display("%0t last mismatch: expected %b actual %b",
                             $time, want.last, res_if.last_of_frame);
                    n_errors++;
                end
                if (want.last)
                    n_frames++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, expected_sums.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int i;
        int phase;
        t_result tr;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pix_if.valid = 1'b0;
        pix_if.pixel = '0;
        res_if.ready = 1'b0;
        no_gaps      = 1'b0;
        cycles       = 0;
        n_errors     = 0;
        n_checked    = 0;
        n_frames     = 0;
        n_pixels     = 0;
        n_writes     = 0;
        n_cut        = 0;
        rnd_sent     = 0;
        for (i = 0; i < LINE_DEPTH; i++) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        for (i = 0; i < 9; i++) begin
            win[i]  = '0;
            coef[i] = '0;
        end
        width_raw  = 11'd1;
        height_raw = 13'd1;
        col_pos    = 0;
        row_pos    = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[j]) begin
            if (directed_rows[j].kind == ROW_CFG) begin
                settle();
                reg_write(directed_rows[j].sel, directed_rows[j].data);
            end else begin
                tr.value = directed_rows[j].exp_value;
                tr.last  = directed_rows[j].exp_last;
                send_pixel(directed_rows[j].pixel, directed_rows[j].typed, tr);
            end
        end

        phase = 0;
        while (rnd_sent < RAND_PIX) begin
            new_setting();
            run_frame(1'b1);
            phase++;
            // oversize width and height, once each
            if (phase == 5)
                run_clamped(64'd2047, 64'd1);
            if (phase == 12)
                run_clamped(64'd1, 64'd8191);
        end

        settle();
        $display("covered %0d pixels, %0d words checked, %0d complete frames, %0d cut short",
                 n_pixels, n_checked, n_frames, n_cut);
        $display("%0d register writes with readback, clamped sizes at both limits",
                 n_writes);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
